// ===== src/dnsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_pkg
// Shared types and constants of the dns first a-record extractor.
// ----------------------------------------------------------------------------
package dnsa_pkg;

  localparam int unsigned MAX_LABELS = 64;
  localparam int unsigned LABEL_CNT_W = 7;
  localparam int unsigned HEADER_LEN = 12;
  localparam int unsigned AFIX_LEN = 10;
  localparam int unsigned QFIX_LEN = 4;
  localparam logic [7:0] MAX_LABEL_LEN = 8'd63;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_NAME    = 4'd1,
    PH_PTR     = 4'd2,
    PH_LABEL   = 4'd3,
    PH_QFIX    = 4'd4,
    PH_AFIX    = 4'd5,
    PH_RDATA   = 4'd6,
    PH_RDATA_A = 4'd7,
    PH_DONE    = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_FOUND   = 3'd0,
    ST_SHORT   = 3'd1,
    ST_NOTRESP = 3'd2,
    ST_RCODE   = 3'd3,
    ST_BAD     = 3'd4,
    ST_NONE    = 3'd5,
    ST_OPEN    = 3'd7
  } status_t;

endpackage : dnsa_pkg
`default_nettype wire

// ===== src/dns_first_a_record_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dns_first_a_record_extractor
// Byte-stream dns response parser that captures the first ipv4 answer.
//
// Input channel: one message byte per transaction (data_byte), last_byte
// high on the final byte. Output channel: one transaction per message,
// carrying found, address and status, issued for the final byte only.
// Each byte is parsed in the cycle it is accepted, so one byte is taken
// every cycle while in_stall is low. The result appears in the output
// register on the cycle after the final byte is accepted. The parse state
// returns to its start values after the final byte, so the next byte
// begins a new message with no gap.
// When the receiver stalls a waiting result, in_stall goes high and holds
// the input channel until the result is taken; a result taken in the same
// cycle frees the register for the next one, so the block keeps full rate.
// Reset (rst, synchronous) clears the parse state and empties the output
// register.
// ----------------------------------------------------------------------------
module dns_first_a_record_extractor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             found,
  output logic [31:0]      address,
  output logic [2:0]       status
);
  import dnsa_pkg::*;

  phase_t                 phase, phase_next;
  logic [3:0]             header_pos, header_pos_next;
  logic [15:0]            flags_word, flags_word_next;
  logic [15:0]            questions_left, questions_left_next;
  logic [15:0]            answers_left, answers_left_next;
  logic [5:0]             label_left, label_left_next;
  logic [LABEL_CNT_W-1:0] labels_seen, labels_seen_next;
  logic [3:0]             fix_pos, fix_pos_next;
  logic [15:0]            record_type, record_type_next;
  logic [15:0]            record_class, record_class_next;
  logic [15:0]            rdata_left, rdata_left_next;
  logic [31:0]            addr_shift, addr_shift_next;
  status_t                outcome, outcome_next;
  status_t                code;
  logic                   in_accept;
  logic [15:0]            q_dec, a_dec;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign q_dec = questions_left - 16'd1;
  assign a_dec = answers_left - 16'd1;

  always_comb begin
    phase_next          = phase;
    header_pos_next     = header_pos;
    flags_word_next     = flags_word;
    questions_left_next = questions_left;
    answers_left_next   = answers_left;
    label_left_next     = label_left;
    labels_seen_next    = labels_seen;
    fix_pos_next        = fix_pos;
    record_type_next    = record_type;
    record_class_next   = record_class;
    rdata_left_next     = rdata_left;
    addr_shift_next     = addr_shift;
    outcome_next        = outcome;

    if (outcome == ST_OPEN) begin
      case (phase)
        PH_HEADER: begin
          if (header_pos == 4'd2 || header_pos == 4'd3)
            flags_word_next = {flags_word[7:0], data_byte};
          else if (header_pos == 4'd4 || header_pos == 4'd5)
            questions_left_next = {questions_left[7:0], data_byte};
          else if (header_pos == 4'd6 || header_pos == 4'd7)
            answers_left_next = {answers_left[7:0], data_byte};
          if (header_pos >= 4'(HEADER_LEN - 1)) begin
            if (!flags_word[15]) begin
              outcome_next = ST_NOTRESP;
              phase_next   = PH_DONE;
            end else if (flags_word[3:0] != 4'd0) begin
              outcome_next = ST_RCODE;
              phase_next   = PH_DONE;
            end else if (questions_left != 16'd0 || answers_left != 16'd0) begin
              labels_seen_next = '0;
              phase_next       = PH_NAME;
            end else begin
              outcome_next = ST_NONE;
              phase_next   = PH_DONE;
            end
          end else begin
            header_pos_next = header_pos + 4'd1;
          end
        end
        PH_NAME: begin
          if (data_byte[7:6] == 2'b11) begin
            phase_next = PH_PTR;
          end else if (data_byte == 8'd0) begin
            fix_pos_next = '0;
            phase_next   = (questions_left != 16'd0) ? PH_QFIX : PH_AFIX;
          end else if (data_byte > MAX_LABEL_LEN ||
                       labels_seen >= LABEL_CNT_W'(MAX_LABELS)) begin
            outcome_next = ST_BAD;
            phase_next   = PH_DONE;
          end else begin
            labels_seen_next = labels_seen + 1'b1;
            label_left_next  = data_byte[5:0];
            phase_next       = PH_LABEL;
          end
        end
        PH_PTR: begin
          fix_pos_next = '0;
          phase_next   = (questions_left != 16'd0) ? PH_QFIX : PH_AFIX;
        end
        PH_LABEL: begin
          label_left_next = label_left - 6'd1;
          if (label_left_next == 6'd0)
            phase_next = PH_NAME;
        end
        PH_QFIX: begin
          fix_pos_next = fix_pos + 4'd1;
          if (fix_pos_next >= 4'(QFIX_LEN)) begin
            questions_left_next = q_dec;
            if (q_dec != 16'd0 || answers_left != 16'd0) begin
              labels_seen_next = '0;
              phase_next       = PH_NAME;
            end else begin
              outcome_next = ST_NONE;
              phase_next   = PH_DONE;
            end
          end
        end
        PH_AFIX: begin
          if (fix_pos < 4'd2)
            record_type_next = {record_type[7:0], data_byte};
          else if (fix_pos < 4'd4)
            record_class_next = {record_class[7:0], data_byte};
          else if (fix_pos >= 4'd8)
            rdata_left_next = {rdata_left[7:0], data_byte};
          fix_pos_next = fix_pos + 4'd1;
          if (fix_pos_next >= 4'(AFIX_LEN)) begin
            if (rdata_left_next == 16'd0) begin
              answers_left_next = a_dec;
              if (questions_left != 16'd0 || a_dec != 16'd0) begin
                labels_seen_next = '0;
                phase_next       = PH_NAME;
              end else begin
                outcome_next = ST_NONE;
                phase_next   = PH_DONE;
              end
            end else if (record_type_next == 16'd1 && record_class_next == 16'd1 &&
                         rdata_left_next == 16'd4) begin
              addr_shift_next = '0;
              phase_next      = PH_RDATA_A;
            end else begin
              phase_next = PH_RDATA;
            end
          end
        end
        PH_RDATA: begin
          rdata_left_next = rdata_left - 16'd1;
          if (rdata_left_next == 16'd0) begin
            answers_left_next = a_dec;
            if (questions_left != 16'd0 || a_dec != 16'd0) begin
              labels_seen_next = '0;
              phase_next       = PH_NAME;
            end else begin
              outcome_next = ST_NONE;
              phase_next   = PH_DONE;
            end
          end
        end
        PH_RDATA_A: begin
          addr_shift_next = {addr_shift[23:0], data_byte};
          rdata_left_next = rdata_left - 16'd1;
          if (rdata_left_next == 16'd0) begin
            outcome_next = ST_FOUND;
            phase_next   = PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    // message ended while still open: short header or truncated
    code = outcome_next;
    if (outcome_next == ST_OPEN)
      code = (phase_next == PH_HEADER) ? ST_SHORT : ST_BAD;
  end

  always_ff @(posedge clk) begin
    if (rst || (in_accept && last_byte)) begin
      phase          <= PH_HEADER;
      header_pos     <= '0;
      flags_word     <= '0;
      questions_left <= '0;
      answers_left   <= '0;
      label_left     <= '0;
      labels_seen    <= '0;
      fix_pos        <= '0;
      record_type    <= '0;
      record_class   <= '0;
      rdata_left     <= '0;
      addr_shift     <= '0;
      outcome        <= ST_OPEN;
    end else if (in_accept) begin
      phase          <= phase_next;
      header_pos     <= header_pos_next;
      flags_word     <= flags_word_next;
      questions_left <= questions_left_next;
      answers_left   <= answers_left_next;
      label_left     <= label_left_next;
      labels_seen    <= labels_seen_next;
      fix_pos        <= fix_pos_next;
      record_type    <= record_type_next;
      record_class   <= record_class_next;
      rdata_left     <= rdata_left_next;
      addr_shift     <= addr_shift_next;
      outcome        <= outcome_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept && last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && last_byte) begin
      found   <= (code == ST_FOUND);
      address <= (code == ST_FOUND) ? addr_shift_next : 32'd0;
      status  <= code;
    end
  end

endmodule : dns_first_a_record_extractor
`default_nettype wire

// ===== src/dnsa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dnsa_checker
// Port-level checks of the dns first a-record extractor, bound to its top.
// ----------------------------------------------------------------------------
module dnsa_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  data_byte,
  input wire logic        last_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        found,
  input wire logic [31:0] address,
  input wire logic [2:0]  status
);
  import dnsa_pkg::*;

  logic [2:0] unused_in;
  logic [7:0] unused_byte;
  assign unused_in   = {in_valid, last_byte, 1'b0};
  assign unused_byte = data_byte;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result transaction dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({found, address, status}))
    else $error("stalled result changed");

  a_found_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> status == ST_FOUND)
    else $error("found result without found status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> address == 32'd0 && status != ST_FOUND &&
                            status <= ST_NONE)
    else $error("miss result with address or bad status");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result register is held");

endmodule : dnsa_checker

bind dns_first_a_record_extractor dnsa_checker u_dnsa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .data_byte (data_byte),
  .last_byte (last_byte),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .found     (found),
  .address   (address),
  .status    (status)
);
`default_nettype wire
